>>> src/nncs_pkg.sv
// Shared types, widths and helpers for the nearest-neighbor crop scaler address engine.
// Used by every module of the block; depends on nothing else.
package nncs_pkg;

  localparam int COORD_BITS      = 12;
  localparam int DIM_BITS        = 16;
  localparam int ADDR_BITS       = 32;
  localparam int BYTES_PER_PIXEL = 2;
  localparam int OUT_COORD_BITS  = 13;
  localparam int CFG_IDX_BITS    = 3;
  localparam int CFG_DATA_BITS   = 32;

  // One restoring division step per cell; the quotient never exceeds DIM_BITS bits.
  localparam int DIV_STEPS = DIM_BITS;
  localparam int PROD_W    = COORD_BITS + DIM_BITS;
  localparam int SEL_W     = DIM_BITS + 1;
  localparam int DIDX_W    = PROD_W + 1;
  localparam int SPROD_W   = SEL_W + DIM_BITS;
  localparam int SIDX_W    = SPROD_W + 1;

  localparam logic [CFG_IDX_BITS-1:0] REG_SOURCE_BASE = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_DEST_BASE   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_SOURCE_SIZE = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_DEST_SIZE   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_ROI_ORIGIN  = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_ROI_EXTENT  = 3'd5;

  typedef struct packed {
    logic [CFG_DATA_BITS-1:0] source_base;
    logic [CFG_DATA_BITS-1:0] dest_base;
    logic [CFG_DATA_BITS-1:0] source_size;
    logic [CFG_DATA_BITS-1:0] dest_size;
    logic [CFG_DATA_BITS-1:0] roi_origin;
    logic [CFG_DATA_BITS-1:0] roi_extent;
  } cfg_t;

  typedef struct packed {
    logic [DIM_BITS-1:0] org_x;
    logic [DIM_BITS-1:0] org_y;
    logic [DIM_BITS-1:0] ext_w;
    logic [DIM_BITS-1:0] ext_h;
  } roi_t;

  // Item moving through the divider chain. Each axis keeps its partial
  // remainder and a word that holds the unused dividend bits on top and
  // the quotient bits produced so far at the bottom.
  typedef struct packed {
    logic                  valid;
    logic                  err;
    logic [COORD_BITS-1:0] col;
    logic [PROD_W-1:0]     dprod;
    logic [DIM_BITS-1:0]   rem_c;
    logic [DIM_BITS-1:0]   dq_c;
    logic [DIM_BITS-1:0]   rem_r;
    logic [DIM_BITS-1:0]   dq_r;
  } div_item_t;

  typedef struct packed {
    logic [OUT_COORD_BITS-1:0] source_col;
    logic [OUT_COORD_BITS-1:0] source_row;
    logic [ADDR_BITS-1:0]      source_address;
    logic [ADDR_BITS-1:0]      dest_address;
    logic                      coordinate_error;
  } res_t;

  // An empty crop window in either direction selects the whole source frame.
  function automatic roi_t eff_roi(cfg_t cfg);
    roi_t r;
    r.org_x = cfg.roi_origin[15:0];
    r.org_y = cfg.roi_origin[31:16];
    r.ext_w = cfg.roi_extent[15:0];
    r.ext_h = cfg.roi_extent[31:16];
    if (r.ext_w == '0 || r.ext_h == '0) begin
      r.org_x = '0;
      r.org_y = '0;
      r.ext_w = cfg.source_size[15:0];
      r.ext_h = cfg.source_size[31:16];
    end
    return r;
  endfunction

endpackage

>>> src/nncs_front.sv
// Entry stage: range check of the destination coordinate and the scaling products.
// Depends on nncs_pkg.
module nncs_front import nncs_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [COORD_BITS-1:0] dest_col_i,
  input  logic [COORD_BITS-1:0] dest_row_i,
  input  cfg_t                  cfg_i,
  output div_item_t             item_o
);

  roi_t                item_roi;
  logic [DIM_BITS-1:0] dst_w;
  logic [DIM_BITS-1:0] dst_h;
  logic [PROD_W-1:0]   prod_c;
  logic [PROD_W-1:0]   prod_r;
  div_item_t           item_d;
  div_item_t           item_q;

  assign item_roi = eff_roi(cfg_i);
  assign dst_w    = cfg_i.dest_size[15:0];
  assign dst_h    = cfg_i.dest_size[31:16];
  assign prod_c   = PROD_W'(dest_col_i) * PROD_W'(item_roi.ext_w);
  assign prod_r   = PROD_W'(dest_row_i) * PROD_W'(item_roi.ext_h);

  // The high part of each dividend is already below the divisor, so the
  // division needs only as many steps as the quotient has bits.
  always_comb begin
    item_d.valid = valid_i;
    item_d.err   = !((DIM_BITS'(dest_col_i) < dst_w) && (DIM_BITS'(dest_row_i) < dst_h));
    item_d.col   = dest_col_i;
    item_d.dprod = PROD_W'(dest_row_i) * PROD_W'(dst_w);
    item_d.rem_c = DIM_BITS'(prod_c[PROD_W-1:DIM_BITS]);
    item_d.dq_c  = prod_c[DIM_BITS-1:0];
    item_d.rem_r = DIM_BITS'(prod_r[PROD_W-1:DIM_BITS]);
    item_d.dq_r  = prod_r[DIM_BITS-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_q.valid <= 1'b0;
    end else if (en_i) begin
      item_q <= item_d;
    end
  end

  assign item_o = item_q;

endmodule

>>> src/nncs_div_cell.sv
// One cell of the divider chain: a restoring division step for column and row.
// Depends on nncs_pkg.
module nncs_div_cell import nncs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic [DIM_BITS-1:0] div_c_i,
  input  logic [DIM_BITS-1:0] div_r_i,
  input  div_item_t           item_i,
  output div_item_t           item_o
);

  logic [DIM_BITS:0] trial_c;
  logic [DIM_BITS:0] trial_r;
  logic              qbit_c;
  logic              qbit_r;
  div_item_t         item_d;
  div_item_t         item_q;

  // Shift the next dividend bit into the remainder and subtract if it fits.
  assign trial_c = {item_i.rem_c, item_i.dq_c[DIM_BITS-1]};
  assign trial_r = {item_i.rem_r, item_i.dq_r[DIM_BITS-1]};
  assign qbit_c  = trial_c >= {1'b0, div_c_i};
  assign qbit_r  = trial_r >= {1'b0, div_r_i};

  always_comb begin
    item_d       = item_i;
    item_d.rem_c = qbit_c ? DIM_BITS'(trial_c - {1'b0, div_c_i}) : trial_c[DIM_BITS-1:0];
    item_d.rem_r = qbit_r ? DIM_BITS'(trial_r - {1'b0, div_r_i}) : trial_r[DIM_BITS-1:0];
    item_d.dq_c  = {item_i.dq_c[DIM_BITS-2:0], qbit_c};
    item_d.dq_r  = {item_i.dq_r[DIM_BITS-2:0], qbit_r};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_q.valid <= 1'b0;
    end else if (en_i) begin
      item_q <= item_d;
    end
  end

  assign item_o = item_q;

endmodule

>>> src/nncs_back.sv
// Address stages after the divider: origin offset, row products and byte addresses.
// Depends on nncs_pkg.
module nncs_back import nncs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  cfg_t      cfg_i,
  input  div_item_t item_i,
  output logic      valid_o,
  output res_t      res_o
);

  typedef struct packed {
    logic                 valid;
    logic                 err;
    logic [SEL_W-1:0]     sel_col;
    logic [SEL_W-1:0]     sel_row;
    logic [ADDR_BITS-1:0] dst_addr;
  } sel_t;

  typedef struct packed {
    logic                 valid;
    logic                 err;
    logic [SEL_W-1:0]     sel_col;
    logic [SEL_W-1:0]     sel_row;
    logic [SPROD_W-1:0]   sprod;
    logic [ADDR_BITS-1:0] dst_addr;
  } prod_t;

  roi_t                 back_roi;
  logic [DIDX_W-1:0]    didx;
  logic [SIDX_W-1:0]    sidx;
  logic [ADDR_BITS-1:0] src_addr;
  sel_t                 sel_d;
  sel_t                 sel_q;
  prod_t                prod_d;
  prod_t                prod_q;

  assign back_roi = eff_roi(cfg_i);
  assign didx     = DIDX_W'(item_i.dprod) + DIDX_W'(item_i.col);

  always_comb begin
    sel_d.valid    = item_i.valid;
    sel_d.err      = item_i.err;
    sel_d.sel_col  = SEL_W'(back_roi.org_x) + SEL_W'(item_i.dq_c);
    sel_d.sel_row  = SEL_W'(back_roi.org_y) + SEL_W'(item_i.dq_r);
    sel_d.dst_addr = cfg_i.dest_base[ADDR_BITS-1:0]
                   + ADDR_BITS'(didx) * ADDR_BITS'(BYTES_PER_PIXEL);
  end

  always_comb begin
    prod_d.valid    = sel_q.valid;
    prod_d.err      = sel_q.err;
    prod_d.sel_col  = sel_q.sel_col;
    prod_d.sel_row  = sel_q.sel_row;
    prod_d.sprod    = SPROD_W'(sel_q.sel_row) * SPROD_W'(cfg_i.source_size[15:0]);
    prod_d.dst_addr = sel_q.dst_addr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q.valid  <= 1'b0;
      prod_q.valid <= 1'b0;
    end else if (en_i) begin
      sel_q  <= sel_d;
      prod_q <= prod_d;
    end
  end

  assign sidx     = SIDX_W'(prod_q.sprod) + SIDX_W'(prod_q.sel_col);
  assign src_addr = cfg_i.source_base[ADDR_BITS-1:0]
                  + ADDR_BITS'(sidx) * ADDR_BITS'(BYTES_PER_PIXEL);

  // A coordinate outside the destination frame returns all-zero fields with coordinate_error set.
  always_comb begin
    res_o.coordinate_error = prod_q.err;
    res_o.source_col       = prod_q.err ? '0 : prod_q.sel_col[OUT_COORD_BITS-1:0];
    res_o.source_row       = prod_q.err ? '0 : prod_q.sel_row[OUT_COORD_BITS-1:0];
    res_o.source_address   = prod_q.err ? '0 : src_addr;
    res_o.dest_address     = prod_q.err ? '0 : prod_q.dst_addr;
  end

  assign valid_o = prod_q.valid;

endmodule

>>> src/nearest_neighbor_crop_scaler_address.sv
// Top level of the nearest-neighbor crop scaler address engine.
// Depends on nncs_pkg, nncs_front, nncs_div_cell and nncs_back.
//
// Usage:
//   Configuration is written through cfg_we_i / cfg_idx_i / cfg_wdata_i while
//   the engine is idle. Indexes 0..5 select source_base, dest_base,
//   source_size, dest_size, roi_origin and roi_extent; other indexes are ignored.
//   The input channel (in_valid_i / in_stall_o) takes one destination column
//   and row per transaction. The output channel (out_valid_o / out_stall_i)
//   returns the source column and row, the source and destination byte
//   addresses and the coordinate error flag, one transaction per input.
//   Throughput is one transaction per clock while in_stall_o is low. A transaction
//   passes one entry stage, a chain of 16 division cells (one quotient bit per
//   cell) and two address stages ahead of the output register.
//   When the receiver stalls, the next result lands in a one-entry skid
//   register, and in_stall_o is high while it is full, freezing the whole chain
//   until the skid entry drains.
//   Reset clears the configuration registers and every valid flag, which
//   empties the pipeline; the data registers keep their contents.
module nearest_neighbor_crop_scaler_address import nncs_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0]  cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [COORD_BITS-1:0]     dest_col_i,
  input  logic [COORD_BITS-1:0]     dest_row_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [OUT_COORD_BITS-1:0] source_col_o,
  output logic [OUT_COORD_BITS-1:0] source_row_o,
  output logic [ADDR_BITS-1:0]      source_address_o,
  output logic [ADDR_BITS-1:0]      dest_address_o,
  output logic                      coordinate_error_o
);

  cfg_t      cfg_q;
  logic      en;
  div_item_t chain [DIV_STEPS+1];
  logic      pipe_valid;
  res_t      pipe_res;
  logic      out_valid_q;
  res_t      out_q;
  logic      skid_valid_q;
  res_t      skid_q;
  logic      out_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SOURCE_BASE: cfg_q.source_base <= cfg_wdata_i;
        REG_DEST_BASE:   cfg_q.dest_base   <= cfg_wdata_i;
        REG_SOURCE_SIZE: cfg_q.source_size <= cfg_wdata_i;
        REG_DEST_SIZE:   cfg_q.dest_size   <= cfg_wdata_i;
        REG_ROI_ORIGIN:  cfg_q.roi_origin  <= cfg_wdata_i;
        REG_ROI_EXTENT:  cfg_q.roi_extent  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // The whole chain moves together unless the skid register is occupied.
  assign en         = !skid_valid_q;
  assign in_stall_o = skid_valid_q;

  nncs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (in_valid_i),
    .dest_col_i (dest_col_i),
    .dest_row_i (dest_row_i),
    .cfg_i      (cfg_q),
    .item_o     (chain[0])
  );

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_cell
    nncs_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .div_c_i (cfg_q.dest_size[15:0]),
      .div_r_i (cfg_q.dest_size[31:16]),
      .item_i  (chain[g]),
      .item_o  (chain[g+1])
    );
  end

  nncs_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .cfg_i   (cfg_q),
    .item_i  (chain[DIV_STEPS]),
    .valid_o (pipe_valid),
    .res_o   (pipe_res)
  );

  assign out_take = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_take) begin
        out_q        <= skid_q;
        skid_valid_q <= 1'b0;
      end
    end else if (pipe_valid) begin
      if (!out_valid_q || out_take) begin
        out_q       <= pipe_res;
        out_valid_q <= 1'b1;
      end else begin
        skid_q       <= pipe_res;
        skid_valid_q <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign source_col_o       = out_q.source_col;
  assign source_row_o       = out_q.source_row;
  assign source_address_o   = out_q.source_address;
  assign dest_address_o     = out_q.dest_address;
  assign coordinate_error_o = out_q.coordinate_error;

endmodule

>>> tb/nearest_neighbor_crop_scaler_address_tb.sv
// Testbench for the nearest-neighbor crop scaler address engine: directed table, then random
// configurations and coordinates checked against a behavioral predictor of the address math.
// Depends on nncs_pkg and nearest_neighbor_crop_scaler_address.
`timescale 1ns / 1ps

module nearest_neighbor_crop_scaler_address_tb;
  import nncs_pkg::*;

  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int DRAIN_CYCLES    = 40;
  localparam int ERRORS_SHOWN    = 10;
  localparam int RANDOM_PHASES   = 7;
  localparam int ITEMS_PER_PHASE = 150;

  // Indexes past the last register; writes to them must leave the setup untouched.
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_7 = 3'd7;

  localparam res_t COORD_ERR_RES = res_t'{13'd0, 13'd0, 32'd0, 32'd0, 1'b1};

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  typedef struct packed {
    logic [2:0]            setup;
    logic [COORD_BITS-1:0] col;
    logic [COORD_BITS-1:0] row;
    logic                  known;
    res_t                  result;
  } dir_row_t;

  logic                      clk_i       = 1'b0;
  logic                      rst_ni      = 1'b0;
  logic                      cfg_we_i    = 1'b0;
  logic [CFG_IDX_BITS-1:0]   cfg_idx_i   = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_wdata_i = '0;
  logic                      in_valid_i  = 1'b0;
  logic                      in_stall_o;
  logic [COORD_BITS-1:0]     dest_col_i  = '0;
  logic [COORD_BITS-1:0]     dest_row_i  = '0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic [OUT_COORD_BITS-1:0] source_col_o;
  logic [OUT_COORD_BITS-1:0] source_row_o;
  logic [ADDR_BITS-1:0]      source_address_o;
  logic [ADDR_BITS-1:0]      dest_address_o;
  logic                      coordinate_error_o;

  cfg_t     active_cfg = '0;
  res_t     expected_addrs[$];
  dir_row_t directed_rows[$];
  logic     typed_known  = 1'b0;
  res_t     typed_result = '0;
  int       sender_idle_pct    = 0;
  int       receiver_stall_pct = 0;
  int       mismatches   = 0;
  int       results_seen = 0;
  int       quiet_cycles = 0;

  nearest_neighbor_crop_scaler_address u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .dest_col_i         (dest_col_i),
    .dest_row_i         (dest_row_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .source_col_o       (source_col_o),
    .source_row_o       (source_row_o),
    .source_address_o   (source_address_o),
    .dest_address_o     (dest_address_o),
    .coordinate_error_o (coordinate_error_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Behavioral address math at 64 bits, truncated to the port widths at the end.
  function automatic res_t predict_pixel_addresses(input cfg_t c,
                                                   input logic [COORD_BITS-1:0] col,
                                                   input logic [COORD_BITS-1:0] row);
    logic [63:0] src_w, src_h, dst_w, dst_h, org_x, org_y, ext_w, ext_h;
    logic [63:0] sel_col, sel_row, src_addr, dst_addr;
    res_t r;
    r = '0;
    src_w = 64'(c.source_size[15:0]);
    src_h = 64'(c.source_size[31:16]);
    dst_w = 64'(c.dest_size[15:0]);
    dst_h = 64'(c.dest_size[31:16]);
    org_x = 64'(c.roi_origin[15:0]);
    org_y = 64'(c.roi_origin[31:16]);
    ext_w = 64'(c.roi_extent[15:0]);
    ext_h = 64'(c.roi_extent[31:16]);
    if (64'(col) >= dst_w || 64'(row) >= dst_h) begin
      r.coordinate_error = 1'b1;
      return r;
    end
    if (ext_w == 64'd0 || ext_h == 64'd0) begin
      org_x = 64'd0;
      org_y = 64'd0;
      ext_w = src_w;
      ext_h = src_h;
    end
    sel_col = org_x + (64'(col) * ext_w) / dst_w;
    sel_row = org_y + (64'(row) * ext_h) / dst_h;
    src_addr = 64'(c.source_base) + 64'(BYTES_PER_PIXEL) * (sel_row * src_w + sel_col);
    dst_addr = 64'(c.dest_base) + 64'(BYTES_PER_PIXEL) * (64'(row) * dst_w + 64'(col));
    r.source_col     = sel_col[OUT_COORD_BITS-1:0];
    r.source_row     = sel_row[OUT_COORD_BITS-1:0];
    r.source_address = src_addr[ADDR_BITS-1:0];
    r.dest_address   = dst_addr[ADDR_BITS-1:0];
    return r;
  endfunction

  function automatic logic [15:0] pick_source_dim();
    case ($urandom_range(0, 9))
      0:       return 16'hFFFF;
      1:       return 16'($urandom);
      2:       return 16'd0;
      default: return 16'($urandom_range(1, 1024));
    endcase
  endfunction

  function automatic logic [15:0] pick_dest_dim();
    case ($urandom_range(0, 15))
      0:       return 16'd0;
      1:       return 16'($urandom);
      2:       return 16'd4096;
      3:       return 16'd1;
      default: return 16'($urandom_range(1, 300));
    endcase
  endfunction

  function automatic cfg_t random_setup();
    cfg_t c;
    c.source_base = $urandom;
    c.dest_base   = $urandom;
    c.source_size = {pick_source_dim(), pick_source_dim()};
    c.dest_size   = {pick_dest_dim(), pick_dest_dim()};
    if ($urandom_range(0, 3) == 0) begin
      c.roi_origin = $urandom;
    end else begin
      c.roi_origin = {16'($urandom_range(0, 255)), 16'($urandom_range(0, 255))};
    end
    case ($urandom_range(0, 5))
      0:       c.roi_extent = 32'd0;
      1:       c.roi_extent = {16'd0, 16'($urandom_range(1, 512))};
      2:       c.roi_extent = $urandom;
      default: c.roi_extent = {16'($urandom_range(1, 512)), 16'($urandom_range(1, 512))};
    endcase
    return c;
  endfunction

  // Mostly inside the destination, sometimes on its last pixel, sometimes anywhere.
  function automatic logic [COORD_BITS-1:0] pick_coord(input logic [15:0] dim);
    int lim;
    lim = (dim > 16'd4096) ? 4096 : int'(dim);
    if (lim == 0 || $urandom_range(0, 99) < 15) return COORD_BITS'($urandom_range(0, 4095));
    if ($urandom_range(0, 9) == 0) return COORD_BITS'(lim - 1);
    return COORD_BITS'($urandom_range(0, lim - 1));
  endfunction

  function automatic void add_directed(input int setup,
                                       input int col, input int row,
                                       input logic known, input res_t result);
    dir_row_t r;
    r.setup  = 3'(setup);
    r.col    = COORD_BITS'(col);
    r.row    = COORD_BITS'(row);
    r.known  = known;
    r.result = result;
    directed_rows.push_back(r);
  endfunction

  task automatic set_idle_mode(input idle_mode_e m);
    case (m)
      IDLE_NONE:     begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
      IDLE_SENDER:   begin sender_idle_pct = 80; receiver_stall_pct = 0;  end
      IDLE_RECEIVER: begin sender_idle_pct = 0;  receiver_stall_pct = 80; end
      default:       begin sender_idle_pct = 8;  receiver_stall_pct = 8;  end
    endcase
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
  endtask

  task automatic apply_config(input cfg_t c);
    write_reg(REG_SOURCE_BASE, c.source_base);
    write_reg(REG_DEST_BASE, c.dest_base);
    write_reg(REG_SOURCE_SIZE, c.source_size);
    write_reg(REG_DEST_SIZE, c.dest_size);
    write_reg(REG_ROI_ORIGIN, c.roi_origin);
    write_reg(REG_ROI_EXTENT, c.roi_extent);
    write_reg(REG_SPARE_6, $urandom);
    write_reg(REG_SPARE_7, $urandom);
    cfg_we_i <= 1'b0;
    active_cfg = c;
  endtask

  // Called at a falling edge; returns at the falling edge after the transaction.
  // Valid is left high so that back-to-back transactions need no extra assignment.
  task automatic send_coordinate(input logic [COORD_BITS-1:0] col,
                                 input logic [COORD_BITS-1:0] row,
                                 input logic known, input res_t result);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    typed_known  = known;
    typed_result = result;
    in_valid_i <= 1'b1;
    dest_col_i <= col;
    dest_row_i <= row;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_addrs.size() != 0) @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < receiver_stall_pct);
  end

  always @(posedge clk_i) begin : monitor
    res_t want;
    logic in_fire, out_fire;
    in_fire  = rst_ni && in_valid_i && !in_stall_o;
    out_fire = rst_ni && out_valid_o && !out_stall_i;
    if (in_fire) begin
      expected_addrs.push_back(typed_known ? typed_result
                               : predict_pixel_addresses(active_cfg, dest_col_i, dest_row_i));
    end
    if (out_fire) begin
      if (expected_addrs.size() == 0) begin
        mismatches++;
        if (mismatches <= ERRORS_SHOWN) begin
          $display("result %0d arrived with nothing expected", results_seen);
        end
      end else begin
        want = expected_addrs.pop_front();
        if (source_col_o !== want.source_col || source_row_o !== want.source_row ||
            source_address_o !== want.source_address ||
            dest_address_o !== want.dest_address ||
            coordinate_error_o !== want.coordinate_error) begin
          mismatches++;
          if (mismatches <= ERRORS_SHOWN) begin
            $display("result %0d: expected col %0d row %0d src %h dst %h err %b",
                     results_seen, want.source_col, want.source_row,
                     want.source_address, want.dest_address, want.coordinate_error);
            $display("result %0d:   actual col %0d row %0d src %h dst %h err %b",
                     results_seen, source_col_o, source_row_o,
                     source_address_o, dest_address_o, coordinate_error_o);
          end
        end
      end
      results_seen++;
    end
    if (in_fire || out_fire) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    cfg_t     setups [0:6];
    dir_row_t r;
    logic [2:0] cur_setup;

    // Setup 0 is the reset state: everything zero, so every coordinate is out of range.
    setups[0] = '0;
    // Whole 640x480 frame scaled to 320x240.
    setups[1] = '{32'h1000_0000, 32'h2000_0000, 32'h01E0_0280, 32'h00F0_0140, 32'd0, 32'd0};
    // Crop window at (10,20) of 100x50, scaled to 200x100.
    setups[2] = '{32'h8000_0100, 32'h0000_4000, 32'h01E0_0280, 32'h0064_00C8,
                  32'h0014_000A, 32'h0032_0064};
    // Every register at its maximum: columns overflow 13 bits and addresses wrap.
    setups[3] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF};
    // Crop width zero with a nonzero height and origin: whole frame is used.
    setups[4] = '{32'h0000_0100, 32'h0000_0200, 32'h0040_0080, 32'h0020_0040,
                  32'h0005_0007, 32'h0010_0000};
    // Destination width zero: everything flags an error.
    setups[5] = '{32'h0000_1234, 32'h0000_5678, 32'h0040_0080, 32'hFFFF_0000,
                  32'h0003_0003, 32'h0000_0010};
    // One-pixel destination from the largest source.
    setups[6] = '{32'd0, 32'd0, 32'hFFFF_FFFF, 32'h0001_0001, 32'd0, 32'd0};

    add_directed(0, 0, 0, 1'b1, COORD_ERR_RES);
    add_directed(0, 4095, 4095, 1'b1, COORD_ERR_RES);
    add_directed(1, 0, 0, 1'b1, res_t'{13'd0, 13'd0, 32'h1000_0000, 32'h2000_0000, 1'b0});
    add_directed(1, 319, 239, 1'b0, '0);
    add_directed(1, 320, 0, 1'b1, COORD_ERR_RES);
    add_directed(1, 0, 240, 1'b1, COORD_ERR_RES);
    add_directed(1, 160, 120, 1'b0, '0);
    add_directed(2, 0, 0, 1'b1, res_t'{13'd10, 13'd20, 32'h8000_6514, 32'h0000_4000, 1'b0});
    add_directed(2, 199, 99, 1'b0, '0);
    add_directed(2, 1, 1, 1'b0, '0);
    add_directed(2, 200, 99, 1'b1, COORD_ERR_RES);
    add_directed(3, 0, 0, 1'b0, '0);
    add_directed(3, 4095, 4095, 1'b0, '0);
    add_directed(3, 4095, 0, 1'b0, '0);
    add_directed(3, 0, 4095, 1'b0, '0);
    add_directed(4, 0, 0, 1'b1, res_t'{13'd0, 13'd0, 32'h0000_0100, 32'h0000_0200, 1'b0});
    add_directed(4, 63, 31, 1'b0, '0);
    add_directed(4, 64, 31, 1'b1, COORD_ERR_RES);
    add_directed(5, 0, 0, 1'b1, COORD_ERR_RES);
    add_directed(5, 5, 5, 1'b0, '0);
    add_directed(6, 0, 0, 1'b1, res_t'{13'd0, 13'd0, 32'd0, 32'd0, 1'b0});
    add_directed(6, 1, 0, 1'b1, COORD_ERR_RES);
    add_directed(6, 0, 1, 1'b1, COORD_ERR_RES);

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    set_idle_mode(IDLE_NONE);
    cur_setup = 3'd0;
    foreach (directed_rows[i]) begin
      r = directed_rows[i];
      if (r.setup != cur_setup) begin
        drain_results();
        apply_config(setups[r.setup]);
        cur_setup = r.setup;
      end
      send_coordinate(r.col, r.row, r.known, r.result);
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain_results();
      apply_config(random_setup());
      set_idle_mode(idle_mode_e'(p % 4));
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_coordinate(pick_coord(active_cfg.dest_size[15:0]),
                        pick_coord(active_cfg.dest_size[31:16]), 1'b0, '0);
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatches == 0 && expected_addrs.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/nncs_pkg.sv
src/nncs_front.sv
src/nncs_div_cell.sv
src/nncs_back.sv
src/nearest_neighbor_crop_scaler_address.sv
tb/nearest_neighbor_crop_scaler_address_tb.sv
